@@ src/rv32i_subset_core_with_mmio_top_macros.svh @@
// Assertion macros for the rv32i subset core checker.
// Used by rvcore_chk.sv; no other dependencies.
`ifndef RV32I_SUBSET_CORE_WITH_MMIO_TOP_MACROS_SVH
`define RV32I_SUBSET_CORE_WITH_MMIO_TOP_MACROS_SVH

// Generic clocked assertion with active-low reset disable.
`define RVC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rvcore assertion failed");

// Same, on the default clock and reset names.
`define RVC_ASSERT_STD(lbl, prop) \
  `RVC_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

@@ src/rvcore_pkg.sv @@
// Package for the rv32i subset core: sizes, opcodes, console addresses, types.
// No dependencies.
`timescale 1ns / 1ps
package rvcore_pkg;

  localparam int CODE_BYTES = 1024;
  localparam int DATA_BYTES = 1024;
  localparam int CODE_AW    = $clog2(CODE_BYTES);
  localparam int DATA_AW    = $clog2(DATA_BYTES);
  localparam int MEM_AW     = 11;
  localparam int PC_W       = 10;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;

  localparam logic [6:0] F7_ALT = 7'h20;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_CHAR  = 3'd1;
  localparam logic [2:0] KIND_INT   = 3'd2;
  localparam logic [2:0] KIND_HEX   = 3'd3;
  localparam logic [2:0] KIND_PC    = 3'd4;
  localparam logic [2:0] KIND_HALT  = 3'd5;
  localparam logic [2:0] KIND_ILL   = 3'd6;
  localparam logic [2:0] KIND_UNIMP = 3'd7;

  localparam logic [31:0] PC_LIMIT    = 32'h0000_0400;
  localparam logic [31:0] MMIO_BASE   = 32'h0000_0800;
  localparam logic [31:0] IO_PUTC     = 32'h0000_0800;
  localparam logic [31:0] IO_PUTI     = 32'h0000_0804;
  localparam logic [31:0] IO_PUTX     = 32'h0000_0808;
  localparam logic [31:0] IO_HALT     = 32'h0000_080C;
  localparam logic [31:0] IO_GETC     = 32'h0000_0812;
  localparam logic [31:0] IO_GETI     = 32'h0000_0816;
  localparam logic [31:0] IO_DUMP_PC  = 32'h0000_0820;
  localparam logic [31:0] IO_RESERVED = 32'h0000_0850;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_REGA, S_REGB, S_EXEC, S_TGT, S_MEM, S_LDW, S_WB
  } state_e;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_SLL, ALU_SLT, ALU_SLTU,
    ALU_XOR, ALU_SRL, ALU_SRA, ALU_OR, ALU_AND
  } alu_op_e;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  waddr;
    logic [31:0] wdata;
    logic [4:0]  raddr;
  } rf_req_t;

  typedef struct packed {
    logic [31:0] result;
    logic        eq;
    logic        lt;
    logic        ltu;
  } alu_res_t;

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ src/rvcore_if.sv @@
// Valid/ready channel interfaces for the core's request and response transactions.
// No dependencies.
`timescale 1ns / 1ps
interface rvcore_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [10:0] load_address;
  logic [7:0]  load_byte;
  logic signed [31:0] console_in;

  modport source (output valid, action, load_address, load_byte, console_in, input ready);
  modport sink   (input valid, action, load_address, load_byte, console_in, output ready);
endinterface

interface rvcore_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  next_pc;
  logic [2:0]  out_kind;
  logic [31:0] out_value;
  logic        console_taken;

  modport source (output valid, next_pc, out_kind, out_value, console_taken, input ready);
  modport sink   (input valid, next_pc, out_kind, out_value, console_taken, output ready);
endinterface

@@ src/rvcore_mem.sv @@
// Byte-wide instruction and data stores, one access per cycle, registered read.
// Depends on rvcore_pkg.
`timescale 1ns / 1ps
module rvcore_mem (
  input  logic                clk_i,
  input  rvcore_pkg::mem_req_t req_i,
  output logic [7:0]          rdata_o
);

  logic [7:0] code_q [rvcore_pkg::CODE_BYTES];
  logic [7:0] data_q [rvcore_pkg::DATA_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.addr[rvcore_pkg::MEM_AW-1]) begin
      if (req_i.we) begin
        code_q[req_i.addr[rvcore_pkg::CODE_AW-1:0]] <= req_i.wdata;
      end
      rdata_q <= code_q[req_i.addr[rvcore_pkg::CODE_AW-1:0]];
    end else if (req_i.en) begin
      if (req_i.we) begin
        data_q[req_i.addr[rvcore_pkg::DATA_AW-1:0]] <= req_i.wdata;
      end
      rdata_q <= data_q[req_i.addr[rvcore_pkg::DATA_AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rvcore_rf.sv @@
// Register file, 32 x 32, one write and one registered read per cycle; x0 reads zero.
// Depends on rvcore_pkg.
`timescale 1ns / 1ps
module rvcore_rf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rvcore_pkg::rf_req_t req_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] regs_q [32];
  logic [31:0] valid_q;
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we && (req_i.waddr != 5'd0)) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr != 5'd0)) begin
      regs_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= valid_q[req_i.raddr] ? regs_q[req_i.raddr] : 32'd0;
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rvcore_alu.sv @@
// Shared ALU: add/sub, shifts, logic ops and compares for the execute and target steps.
// Depends on rvcore_pkg.
`timescale 1ns / 1ps
module rvcore_alu (
  input  rvcore_pkg::alu_op_e  op_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  output rvcore_pkg::alu_res_t res_o
);

  logic        lt_s;
  logic        lt_u;
  logic [4:0]  sh;

  always_comb begin
    lt_s = $signed(a_i) < $signed(b_i);
    lt_u = a_i < b_i;
    sh   = b_i[4:0];
    res_o.eq  = (a_i == b_i);
    res_o.lt  = lt_s;
    res_o.ltu = lt_u;
    case (op_i)
      rvcore_pkg::ALU_ADD:  res_o.result = a_i + b_i;
      rvcore_pkg::ALU_SUB:  res_o.result = a_i - b_i;
      rvcore_pkg::ALU_SLL:  res_o.result = a_i << sh;
      rvcore_pkg::ALU_SLT:  res_o.result = {31'd0, lt_s};
      rvcore_pkg::ALU_SLTU: res_o.result = {31'd0, lt_u};
      rvcore_pkg::ALU_XOR:  res_o.result = a_i ^ b_i;
      rvcore_pkg::ALU_SRL:  res_o.result = a_i >> sh;
      rvcore_pkg::ALU_SRA:  res_o.result = 32'($signed(a_i) >>> sh);
      rvcore_pkg::ALU_OR:   res_o.result = a_i | b_i;
      rvcore_pkg::ALU_AND:  res_o.result = a_i & b_i;
      default:              res_o.result = a_i + b_i;
    endcase
  end

endmodule

@@ src/rv32i_subset_core_with_mmio_top.sv @@
// Top level: sequencer around a shared ALU, register file and byte stores.
// Steps: an image-byte load or a step while stopped goes from accept to write-back; an
// instruction runs fetch, two reg reads, exec, target, memory (+ load wait), write-back.
// Throughput: one transaction at a time, set by byte-serial fetch through one memory port.
// Reset: registers zero, pc zero, core running; byte stores undefined until written.
`timescale 1ns / 1ps
module rv32i_subset_core_with_mmio_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  rvcore_in_if.sink           req_i,
  rvcore_out_if.source        rsp_o
);

  rvcore_pkg::state_e   state_q, state_d;
  rvcore_pkg::mem_req_t mem_req;
  rvcore_pkg::rf_req_t  rf_req;
  rvcore_pkg::alu_op_e  alu_op;
  rvcore_pkg::alu_res_t alu_res;
  logic [31:0] alu_a, alu_b;
  logic [7:0]  mem_rdata;
  logic [31:0] rf_rdata;

  logic [9:0]  pc_q;
  logic        stopped_q;
  logic [1:0]  cnt_q;
  logic        rd_vld_q, rd_dst_q;
  logic [1:0]  rd_idx_q;
  logic        out_vld_q;
  logic [9:0]  out_pc_q;
  logic [2:0]  kind_q;
  logic [31:0] value_q;
  logic        taken_q;

  logic [31:0] w_q, ld_q, a_q, b_q, res_q, npc_q, con_q;
  logic        take_q, trivial_q;

  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, link;
  logic [2:0]  mem_n;
  logic        is_load, commit;

  logic [2:0]  kind;
  logic [31:0] value;
  logic        taken, hold, wr_en, stop_now, pc_upd;
  logic [31:0] wr_data;

  assign opc   = w_q[6:0];
  assign rd    = w_q[11:7];
  assign f3    = w_q[14:12];
  assign rs1   = w_q[19:15];
  assign rs2   = w_q[24:20];
  assign f7    = w_q[31:25];
  assign imm_i = {{20{w_q[31]}}, w_q[31:20]};
  assign imm_s = {{20{w_q[31]}}, w_q[31:25], w_q[11:7]};
  assign imm_b = {{19{w_q[31]}}, w_q[31], w_q[7], w_q[30:25], w_q[11:8], 1'b0};
  assign imm_j = {{11{w_q[31]}}, w_q[31], w_q[19:12], w_q[20], w_q[30:21], 1'b0};
  assign link  = {22'd0, pc_q} + 32'd4;
  assign is_load = (opc == rvcore_pkg::OPC_LOAD);
  assign commit  = (state_q == rvcore_pkg::S_WB) && (!out_vld_q || rsp_o.ready);

  always_comb begin
    mem_n = 3'd0;
    if (is_load && (rd != 5'd0) && (res_q < rvcore_pkg::MMIO_BASE)) begin
      case (f3)
        3'd0, 3'd4: mem_n = 3'd1;
        3'd1, 3'd5: mem_n = 3'd2;
        3'd2:       mem_n = 3'd4;
        default:    mem_n = 3'd0;
      endcase
    end else if ((opc == rvcore_pkg::OPC_STORE) && (res_q < rvcore_pkg::MMIO_BASE)) begin
      case (f3)
        3'd0:    mem_n = 3'd1;
        3'd1:    mem_n = 3'd2;
        3'd2:    mem_n = 3'd4;
        default: mem_n = 3'd0;
      endcase
    end
  end

  rvcore_mem u_mem (.clk_i(clk_i), .req_i(mem_req), .rdata_o(mem_rdata));
  rvcore_rf  u_rf  (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(rf_req), .rdata_o(rf_rdata));
  rvcore_alu u_alu (.op_i(alu_op), .a_i(alu_a), .b_i(alu_b), .res_o(alu_res));

  assign req_i.ready = (state_q == rvcore_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rvcore_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    mem_req       = '0;
    rf_req        = '0;
    rf_req.raddr  = rs1;
    alu_op        = rvcore_pkg::ALU_ADD;
    alu_a         = a_q;
    alu_b         = b_q;
    case (state_q)
      rvcore_pkg::S_IDLE: begin
        if (req_i.valid) begin
          if (!req_i.action) begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = req_i.load_address;
            mem_req.wdata = req_i.load_byte;
            state_d       = rvcore_pkg::S_WB;
          end else if (stopped_q) begin
            state_d = rvcore_pkg::S_WB;
          end else begin
            state_d = rvcore_pkg::S_FETCH;
          end
        end
      end
      rvcore_pkg::S_FETCH: begin
        mem_req.en   = 1'b1;
        mem_req.addr = {1'b0, pc_q + {8'd0, cnt_q}};
        if (cnt_q == 2'd3) begin
          state_d = rvcore_pkg::S_REGA;
        end
      end
      rvcore_pkg::S_REGA: begin
        rf_req.raddr = rs1;
        state_d      = rvcore_pkg::S_REGB;
      end
      rvcore_pkg::S_REGB: begin
        rf_req.raddr = rs2;
        state_d      = rvcore_pkg::S_EXEC;
      end
      rvcore_pkg::S_EXEC: begin
        alu_a = a_q;
        case (opc)
          rvcore_pkg::OPC_OP: begin
            alu_b = rf_rdata;
            case (f3)
              3'd0:    alu_op = f7[5] ? rvcore_pkg::ALU_SUB : rvcore_pkg::ALU_ADD;
              3'd1:    alu_op = rvcore_pkg::ALU_SLL;
              3'd2:    alu_op = rvcore_pkg::ALU_SLT;
              3'd3:    alu_op = rvcore_pkg::ALU_SLTU;
              3'd4:    alu_op = rvcore_pkg::ALU_XOR;
              3'd5:    alu_op = f7[5] ? rvcore_pkg::ALU_SRA : rvcore_pkg::ALU_SRL;
              3'd6:    alu_op = rvcore_pkg::ALU_OR;
              default: alu_op = rvcore_pkg::ALU_AND;
            endcase
          end
          rvcore_pkg::OPC_OPIMM: begin
            alu_b = imm_i;
            case (f3)
              3'd2:    alu_op = rvcore_pkg::ALU_SLT;
              3'd3:    alu_op = rvcore_pkg::ALU_SLTU;
              3'd4:    alu_op = rvcore_pkg::ALU_XOR;
              3'd6:    alu_op = rvcore_pkg::ALU_OR;
              3'd7:    alu_op = rvcore_pkg::ALU_AND;
              default: alu_op = rvcore_pkg::ALU_ADD;
            endcase
          end
          rvcore_pkg::OPC_BRANCH: begin
            alu_b  = rf_rdata;
            alu_op = rvcore_pkg::ALU_SUB;
          end
          rvcore_pkg::OPC_STORE: alu_b = imm_s;
          default:               alu_b = imm_i;
        endcase
        state_d = rvcore_pkg::S_TGT;
      end
      rvcore_pkg::S_TGT: begin
        alu_a = {22'd0, pc_q};
        if ((opc == rvcore_pkg::OPC_BRANCH) && take_q) begin
          alu_b = imm_b;
        end else if (opc == rvcore_pkg::OPC_JAL) begin
          alu_b = imm_j;
        end else begin
          alu_b = 32'd4;
        end
        state_d = rvcore_pkg::S_MEM;
      end
      rvcore_pkg::S_MEM: begin
        if (mem_n == 3'd0) begin
          state_d = rvcore_pkg::S_WB;
        end else begin
          mem_req.en    = 1'b1;
          mem_req.we    = !is_load;
          mem_req.addr  = res_q[10:0] + {9'd0, cnt_q};
          mem_req.wdata = b_q[8*cnt_q +: 8];
          if ({1'b0, cnt_q} == mem_n - 3'd1) begin
            state_d = is_load ? rvcore_pkg::S_LDW : rvcore_pkg::S_WB;
          end
        end
      end
      rvcore_pkg::S_LDW: state_d = rvcore_pkg::S_WB;
      rvcore_pkg::S_WB: begin
        if (commit) begin
          rf_req.we    = wr_en;
          rf_req.waddr = rd;
          rf_req.wdata = wr_data;
          state_d      = rvcore_pkg::S_IDLE;
        end
      end
      default: state_d = rvcore_pkg::S_IDLE;
    endcase
  end

  // result of the instruction, evaluated in write-back
  always_comb begin
    kind    = rvcore_pkg::KIND_NONE;
    value   = 32'd0;
    taken   = 1'b0;
    hold    = 1'b0;
    wr_en   = 1'b0;
    wr_data = res_q;
    if (!trivial_q) begin
      case (opc)
        rvcore_pkg::OPC_OP: begin
          wr_en = (f7 == 7'd0) || ((f7 == rvcore_pkg::F7_ALT) && (f3 inside {3'd0, 3'd5}));
        end
        rvcore_pkg::OPC_OPIMM: wr_en = !(f3 inside {3'd1, 3'd5});
        rvcore_pkg::OPC_LOAD: begin
          if (rd != 5'd0) begin
            if (res_q < rvcore_pkg::MMIO_BASE) begin
              wr_en = 1'b1;
              case (f3)
                3'd0:    wr_data = rvcore_pkg::sext8(ld_q[7:0]);
                3'd1:    wr_data = rvcore_pkg::sext16(ld_q[15:0]);
                3'd2:    wr_data = ld_q;
                3'd4:    wr_data = {24'd0, ld_q[7:0]};
                3'd5:    wr_data = {16'd0, ld_q[15:0]};
                default: wr_en   = 1'b0;
              endcase
            end else if (res_q == rvcore_pkg::IO_GETC) begin
              wr_en   = 1'b1;
              wr_data = rvcore_pkg::sext8(con_q[7:0]);
              taken   = 1'b1;
            end else if (res_q == rvcore_pkg::IO_GETI) begin
              wr_en   = 1'b1;
              wr_data = con_q;
              taken   = 1'b1;
            end
          end
        end
        rvcore_pkg::OPC_STORE: begin
          if (res_q == rvcore_pkg::IO_PUTC) begin
            kind  = rvcore_pkg::KIND_CHAR;
            value = {24'd0, b_q[7:0]};
          end else if (res_q == rvcore_pkg::IO_PUTI) begin
            kind  = rvcore_pkg::KIND_INT;
            value = b_q;
          end else if (res_q == rvcore_pkg::IO_PUTX) begin
            kind  = rvcore_pkg::KIND_HEX;
            value = b_q;
          end else if (res_q == rvcore_pkg::IO_HALT) begin
            kind  = rvcore_pkg::KIND_HALT;
          end else if (res_q == rvcore_pkg::IO_DUMP_PC) begin
            kind  = rvcore_pkg::KIND_PC;
            value = {22'd0, pc_q};
          end else if (res_q >= rvcore_pkg::IO_RESERVED) begin
            hold  = 1'b1;
          end
        end
        rvcore_pkg::OPC_BRANCH: wr_en = 1'b0;
        rvcore_pkg::OPC_JAL: begin
          wr_en   = 1'b1;
          wr_data = link;
        end
        rvcore_pkg::OPC_JALR: begin
          wr_en   = (f3 == 3'd0);
          wr_data = link;
        end
        rvcore_pkg::OPC_LUI: begin
          wr_en   = 1'b1;
          wr_data = {w_q[31:12], 12'd0};
        end
        default: begin
          kind  = rvcore_pkg::KIND_UNIMP;
          value = w_q;
        end
      endcase
    end
    stop_now = 1'b0;
    pc_upd   = 1'b0;
    if (!trivial_q) begin
      if ((kind == rvcore_pkg::KIND_HALT) || (kind == rvcore_pkg::KIND_UNIMP)) begin
        stop_now = 1'b1;
      end else if (!hold) begin
        if (npc_q >= rvcore_pkg::PC_LIMIT) begin
          kind     = rvcore_pkg::KIND_ILL;
          value    = w_q;
          stop_now = 1'b1;
        end else begin
          pc_upd = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= '0;
      stopped_q <= 1'b0;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_dst_q  <= 1'b0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q    <= ((state_q == rvcore_pkg::S_FETCH) || (state_q == rvcore_pkg::S_MEM)) ?
                  cnt_q + 2'd1 : 2'd0;
      rd_vld_q <= mem_req.en && !mem_req.we;
      rd_dst_q <= (state_q == rvcore_pkg::S_MEM);
      rd_idx_q <= cnt_q;
      if (commit) begin
        out_vld_q <= 1'b1;
        if (pc_upd) begin
          pc_q <= npc_q[9:0];
        end
        if (stop_now) begin
          stopped_q <= 1'b1;
        end
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      con_q     <= req_i.console_in;
      trivial_q <= !req_i.action || stopped_q;
    end
    if (rd_vld_q) begin
      if (rd_dst_q) begin
        ld_q[8*rd_idx_q +: 8] <= mem_rdata;
      end else begin
        w_q[8*rd_idx_q +: 8] <= mem_rdata;
      end
    end
    if (state_q == rvcore_pkg::S_REGB) begin
      a_q <= rf_rdata;
    end
    if (state_q == rvcore_pkg::S_EXEC) begin
      b_q   <= rf_rdata;
      res_q <= alu_res.result;
      case (f3)
        3'd0:    take_q <= alu_res.eq;
        3'd1:    take_q <= !alu_res.eq;
        3'd4:    take_q <= alu_res.lt;
        3'd5:    take_q <= !alu_res.lt;
        3'd6:    take_q <= alu_res.ltu;
        3'd7:    take_q <= !alu_res.ltu;
        default: take_q <= 1'b0;
      endcase
    end
    if (state_q == rvcore_pkg::S_TGT) begin
      npc_q <= ((opc == rvcore_pkg::OPC_JALR) && (f3 == 3'd0)) ?
               {res_q[31:1], 1'b0} : alu_res.result;
    end
    if (commit) begin
      out_pc_q <= pc_upd ? npc_q[9:0] : pc_q;
      kind_q   <= kind;
      value_q  <= value;
      taken_q  <= taken;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.next_pc       = out_pc_q;
  assign rsp_o.out_kind      = kind_q;
  assign rsp_o.out_value     = value_q;
  assign rsp_o.console_taken = taken_q;

endmodule

@@ src/rvcore_chk.sv @@
// Port-level checker for the rv32i subset core, bound to the top level.
// Depends on rv32i_subset_core_with_mmio_top_macros.svh.
`timescale 1ns / 1ps
`include "rv32i_subset_core_with_mmio_top_macros.svh"
module rvcore_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  out_kind_i,
  input logic [31:0] out_value_i,
  input logic        console_taken_i
);

  `RVC_ASSERT_STD(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `RVC_ASSERT_STD(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i)
  `RVC_ASSERT_STD(a_quiet_value, out_valid_i && (out_kind_i == 3'd0 || out_kind_i == 3'd5) |-> out_value_i == 32'd0)
  `RVC_ASSERT_STD(a_taken_kind, out_valid_i && console_taken_i |-> out_kind_i == 3'd0 || out_kind_i == 3'd6)

endmodule

bind rv32i_subset_core_with_mmio_top rvcore_chk u_rvcore_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .out_kind_i      (rsp_o.out_kind),
  .out_value_i     (rsp_o.out_value),
  .console_taken_i (rsp_o.console_taken)
);
